// ===== design/mts_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and codes of the multitouch slot tracker.
// ----------------------------------------------------------------------------
package mts_pkg;

    // field widths
    localparam int POS_W  = 12;
    localparam int PX_W   = 13;
    localparam int SLOT_W = 4;
    localparam int VAL_W  = 32;

    localparam logic [POS_W-1:0] POS_MAX           = 12'd4095;
    localparam logic [POS_W-1:0] SCREEN_WIDTH_INIT = 12'd800;

    // request commands
    localparam logic [1:0] CMD_AXIS  = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // absolute axis codes
    localparam logic [2:0] AXIS_SLOT   = 3'd0;
    localparam logic [2:0] AXIS_TRK_ID = 3'd1;
    localparam logic [2:0] AXIS_POS_X  = 3'd2;
    localparam logic [2:0] AXIS_POS_Y  = 3'd3;

    typedef struct packed {
        logic [1:0]              cmd;
        logic [2:0]              axis_code;
        logic signed [VAL_W-1:0] value;
        logic                    block_drawing;
    } t_in_item;

    typedef struct packed {
        logic signed [PX_W-1:0] pointer_x;
        logic [POS_W-1:0]       pointer_y;
        logic                   pointer_down;
        logic                   pointer_released;
        logic                   point_valid;
        logic                   stroke_end;
    } t_out_item;

    // lowest active slot as seen by the frame logic
    typedef struct packed {
        logic             any_active;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
    } t_slot_sel;

endpackage
`default_nettype wire

// ===== design/mts_slot_bank.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mts_slot_bank
// Per-slot contact records, slot select and lowest-active-slot lookup.
// ----------------------------------------------------------------------------
module mts_slot_bank #(
    parameter int NUM_SLOTS = 10
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_fire,
    input  mts_pkg::t_in_item   i_item,
    output mts_pkg::t_slot_sel  o_sel
);

    logic [mts_pkg::POS_W-1:0]  r_slot_x [NUM_SLOTS];
    logic [mts_pkg::POS_W-1:0]  r_slot_y [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]       r_slot_active;
    logic [mts_pkg::SLOT_W-1:0] r_cur_slot;

    logic [mts_pkg::POS_W-1:0]  n_slot_x [NUM_SLOTS];
    logic [mts_pkg::POS_W-1:0]  n_slot_y [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]       n_slot_active;
    logic [mts_pkg::SLOT_W-1:0] n_cur_slot;

    logic [mts_pkg::SLOT_W-1:0] w_idx;
    logic [mts_pkg::POS_W-1:0]  w_pos;
    logic                       w_slot_bad;

    // write index, out-of-range falls back to slot 0
    assign w_idx = ({1'b0, r_cur_slot} < (mts_pkg::SLOT_W+1)'(NUM_SLOTS)) ? r_cur_slot : '0;

    // saturate raw position to 0..4095
    always_comb begin
        if (i_item.value[mts_pkg::VAL_W-1]) begin
            w_pos = '0;
        end else if (i_item.value[mts_pkg::VAL_W-2:mts_pkg::POS_W] != '0) begin
            w_pos = mts_pkg::POS_MAX;
        end else begin
            w_pos = i_item.value[mts_pkg::POS_W-1:0];
        end
    end

    assign w_slot_bad = i_item.value[mts_pkg::VAL_W-1] ||
        (i_item.value[mts_pkg::VAL_W-2:0] >= (mts_pkg::VAL_W-1)'(NUM_SLOTS));

    // event decode and record update
    always_comb begin
        n_slot_x      = r_slot_x;
        n_slot_y      = r_slot_y;
        n_slot_active = r_slot_active;
        n_cur_slot    = r_cur_slot;
        if (i_fire && (i_item.cmd == mts_pkg::CMD_AXIS)) begin
            unique case (i_item.axis_code)
                mts_pkg::AXIS_SLOT: begin
                    n_cur_slot = w_slot_bad ? '0 : i_item.value[mts_pkg::SLOT_W-1:0];
                end
                mts_pkg::AXIS_TRK_ID: begin
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (w_idx == mts_pkg::SLOT_W'(i)) begin
                            n_slot_active[i] = !i_item.value[mts_pkg::VAL_W-1];
                        end
                    end
                end
                // panel is rotated: x goes to the y store and y to the x store
                mts_pkg::AXIS_POS_X: begin
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (w_idx == mts_pkg::SLOT_W'(i)) begin
                            n_slot_y[i] = w_pos;
                        end
                    end
                end
                mts_pkg::AXIS_POS_Y: begin
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (w_idx == mts_pkg::SLOT_W'(i)) begin
                            n_slot_x[i] = w_pos;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_slot_x[i] <= '0;
                r_slot_y[i] <= '0;
            end
            r_slot_active <= '0;
            r_cur_slot    <= '0;
        end else begin
            r_slot_x      <= n_slot_x;
            r_slot_y      <= n_slot_y;
            r_slot_active <= n_slot_active;
            r_cur_slot    <= n_cur_slot;
        end
    end

    // lowest active slot, priority from the top down so slot 0 wins
    always_comb begin
        o_sel.any_active = |r_slot_active;
        o_sel.x          = '0;
        o_sel.y          = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (r_slot_active[i]) begin
                o_sel.x = r_slot_x[i];
                o_sel.y = r_slot_y[i];
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/mts_frame.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mts_frame
// Pointer and stroke state, builds the result of a frame tick.
// ----------------------------------------------------------------------------
module mts_frame (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_fire,
    input  mts_pkg::t_in_item          i_item,
    input  mts_pkg::t_slot_sel         i_sel,
    input  wire [mts_pkg::POS_W-1:0]   i_screen_width,
    output mts_pkg::t_out_item         o_result
);

    logic                      r_pos_upd;
    logic                      r_was_touching;
    logic [mts_pkg::PX_W-1:0]  r_last_px;
    logic [mts_pkg::POS_W-1:0] r_last_py;
    logic                      r_drawing;
    logic                      r_pending;

    logic                      n_pos_upd;
    logic                      n_was_touching;
    logic [mts_pkg::PX_W-1:0]  n_last_px;
    logic [mts_pkg::POS_W-1:0] n_last_py;
    logic                      n_drawing;
    logic                      n_pending;
    logic                      w_released;
    logic                      w_point;
    logic                      w_end;

    // state update per request
    always_comb begin
        n_pos_upd      = r_pos_upd;
        n_was_touching = r_was_touching;
        n_last_px      = r_last_px;
        n_last_py      = r_last_py;
        n_drawing      = r_drawing;
        n_pending      = r_pending;
        w_released     = 1'b0;
        w_point        = 1'b0;
        w_end          = 1'b0;
        if (i_fire) begin
            unique case (i_item.cmd)
                mts_pkg::CMD_AXIS: begin
                    if ((i_item.axis_code == mts_pkg::AXIS_POS_X) ||
                        (i_item.axis_code == mts_pkg::AXIS_POS_Y)) begin
                        n_pos_upd = 1'b1;
                    end
                end
                mts_pkg::CMD_CLEAR: begin
                    n_pending = 1'b0;
                end
                mts_pkg::CMD_TICK: begin
                    if (i_sel.any_active) begin
                        // mirror x against the screen width
                        n_last_px = {1'b0, i_screen_width} - {1'b0, i_sel.x};
                        n_last_py = i_sel.y;
                        if (r_pos_upd && !i_item.block_drawing) begin
                            w_point   = 1'b1;
                            n_pending = 1'b1;
                            n_drawing = 1'b1;
                        end
                    end else begin
                        if (r_drawing && r_pending) begin
                            w_end     = 1'b1;
                            n_pending = 1'b0;
                        end
                        n_drawing = 1'b0;
                    end
                    w_released     = r_was_touching && !i_sel.any_active;
                    n_was_touching = i_sel.any_active;
                    n_pos_upd      = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_upd      <= 1'b0;
            r_was_touching <= 1'b0;
            r_last_px      <= '0;
            r_last_py      <= '0;
            r_drawing      <= 1'b0;
            r_pending      <= 1'b0;
        end else begin
            r_pos_upd      <= n_pos_upd;
            r_was_touching <= n_was_touching;
            r_last_px      <= n_last_px;
            r_last_py      <= n_last_py;
            r_drawing      <= n_drawing;
            r_pending      <= n_pending;
        end
    end

    // result fields, only taken on a frame tick
    always_comb begin
        o_result.pointer_x        = n_last_px;
        o_result.pointer_y        = n_last_py;
        o_result.pointer_down     = i_sel.any_active;
        o_result.pointer_released = w_released;
        o_result.point_valid      = w_point;
        o_result.stroke_end       = w_end;
    end

endmodule
`default_nettype wire

// ===== design/multitouch_slot_tracker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// multitouch_slot_tracker
// Contact tracker for a stream of absolute-axis touch events.
// ----------------------------------------------------------------------------
// Takes one request per cycle. A request is registered on acceptance and
// applied to the slot records and pointer state when it leaves the input
// register, which is a single pass through the slot priority encode and one
// 13-bit subtract; a frame tick's result then goes to the result register.
// Axis events and clear requests give no result. The result register lets
// the next request in while a result still waits; only a frame tick that
// meets a full, stalled result register holds the input side.
// ----------------------------------------------------------------------------
module multitouch_slot_tracker #(
    parameter int NUM_SLOTS = 10
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_in_valid,
    output logic                      o_in_stall,
    input  mts_pkg::t_in_item         i_in_item,
    output logic                      o_out_valid,
    input  wire                       i_out_stall,
    output mts_pkg::t_out_item        o_out_item,
    input  wire                       i_cfg_wr_en,
    input  wire [mts_pkg::POS_W-1:0]  i_cfg_wr_data
);

    logic                      r_in_valid;
    mts_pkg::t_in_item         r_in_item;
    logic                      r_out_valid;
    mts_pkg::t_out_item        r_out_item;
    logic [mts_pkg::POS_W-1:0] r_screen_width;

    logic                      w_is_tick;
    logic                      w_fire;
    logic                      w_accept;
    mts_pkg::t_slot_sel        w_sel;
    mts_pkg::t_out_item        w_result;

    // request stage advances unless a tick meets a blocked result register
    assign w_is_tick  = (r_in_item.cmd == mts_pkg::CMD_TICK);
    assign w_fire     = r_in_valid && (!w_is_tick || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_fire;
    assign w_accept   = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_item <= i_in_item;
        end
    end

    // screen width register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width <= mts_pkg::SCREEN_WIDTH_INIT;
        end else if (i_cfg_wr_en) begin
            r_screen_width <= i_cfg_wr_data;
        end
    end

    mts_slot_bank #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_slot_bank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_item  (r_in_item),
        .o_sel   (w_sel)
    );

    mts_frame u_frame (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (w_fire),
        .i_item         (r_in_item),
        .i_sel          (w_sel),
        .i_screen_width (r_screen_width),
        .o_result       (w_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_is_tick) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_is_tick) begin
            r_out_item <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTHESIS
    // a processed tick always lands in the result register
    a_tick_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_is_tick) |=> o_out_valid)
        else $error("frame tick result not loaded");

    // input side only held when a request is waiting
    a_stall_needs_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked tick");

    a_release_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.pointer_released) |-> !o_out_item.pointer_down)
        else $error("release reported while pointer down");

    a_point_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.point_valid) |-> o_out_item.pointer_down)
        else $error("stroke point reported with pointer up");

    a_end_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.stroke_end) |-> !o_out_item.pointer_down)
        else $error("stroke end reported with pointer down");
`endif

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multitouch slot tracker.
// ----------------------------------------------------------------------------
// Drives slot, tracking id and position events, frame ticks and clears
// through the valid/stall request channel. A scoreboard class keeps its own
// copy of the slot records and pointer state and predicts each frame result.
// Both sides idle at random. The receiver holds off once in a while for a
// long stretch so that the block backs up. The screen width is changed
// between phases, extremes included.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int NUM_SLOTS      = 10;
    localparam int ITEM_TARGET    = 950;
    localparam int PHASE_ITEMS    = 190;
    localparam int MAX_WAIT       = 17;
    localparam int LONG_HOLD      = 400;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;

    // codes the package leaves unnamed
    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam logic [2:0] AXIS_IGNORED = 3'd4;
    localparam logic [2:0] AXIS_TOP     = 3'd7;

    // frame result predictor and store of expected frame results
    class slot_scoreboard;
        logic [mts_pkg::POS_W-1:0]  width_reg;
        logic [mts_pkg::POS_W-1:0]  rec_x [NUM_SLOTS];
        logic [mts_pkg::POS_W-1:0]  rec_y [NUM_SLOTS];
        logic                       rec_active [NUM_SLOTS];
        logic [mts_pkg::SLOT_W-1:0] sel_slot;
        logic                       moved;
        logic                       touched;
        logic [mts_pkg::PX_W-1:0]   held_x;
        logic [mts_pkg::POS_W-1:0]  held_y;
        logic                       stroke_open;
        logic                       points_held;
        mts_pkg::t_out_item         frame_q[$];
        int                         mismatches;
        int                         frames_seen;
        int                         points;
        int                         stroke_ends;
        int                         releases;

        function new();
            width_reg   = mts_pkg::SCREEN_WIDTH_INIT;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                rec_x[i]      = '0;
                rec_y[i]      = '0;
                rec_active[i] = 1'b0;
            end
            sel_slot    = '0;
            moved       = 1'b0;
            touched     = 1'b0;
            held_x      = '0;
            held_y      = '0;
            stroke_open = 1'b0;
            points_held = 1'b0;
            mismatches  = 0;
            frames_seen = 0;
            points      = 0;
            stroke_ends = 0;
            releases    = 0;
        endfunction

        function void set_width(logic [mts_pkg::POS_W-1:0] w);
            width_reg = w;
        endfunction

        function int pending();
            return frame_q.size();
        endfunction

        // negative positions clamp to 0, large ones to the panel maximum
        function logic [mts_pkg::POS_W-1:0] clamp_position(int v);
            if (v < 0) return '0;
            if (v > int'(mts_pkg::POS_MAX)) return mts_pkg::POS_MAX;
            return v[mts_pkg::POS_W-1:0];
        endfunction

        // apply one accepted request, queue a frame result on a tick
        function void note_request(mts_pkg::t_in_item it);
            int                 v;
            int                 found;
            mts_pkg::t_out_item res;
            v     = $signed(it.value);
            found = -1;
            res   = '0;
            case (it.cmd)
                mts_pkg::CMD_AXIS: begin
                    case (it.axis_code)
                        mts_pkg::AXIS_SLOT: begin
                            if (v < 0 || v >= NUM_SLOTS) sel_slot = '0;
                            else sel_slot = v[mts_pkg::SLOT_W-1:0];
                        end
                        mts_pkg::AXIS_TRK_ID: rec_active[sel_slot] = (v >= 0);
                        // panel is rotated: x lands in the y record and back
                        mts_pkg::AXIS_POS_X: begin
                            rec_y[sel_slot] = clamp_position(v);
                            moved = 1'b1;
                        end
                        mts_pkg::AXIS_POS_Y: begin
                            rec_x[sel_slot] = clamp_position(v);
                            moved = 1'b1;
                        end
                        default: ;
                    endcase
                end
                mts_pkg::CMD_CLEAR: points_held = 1'b0;
                mts_pkg::CMD_TICK: begin
                    for (int i = NUM_SLOTS - 1; i >= 0; i--)
                        if (rec_active[i]) found = i;
                    if (found >= 0) begin
                        held_x = {1'b0, width_reg} - {1'b0, rec_x[found]};
                        held_y = rec_y[found];
                        if (moved && !it.block_drawing) begin
                            res.point_valid = 1'b1;
                            points_held     = 1'b1;
                            stroke_open     = 1'b1;
                        end
                    end else begin
                        if (stroke_open && points_held) begin
                            res.stroke_end = 1'b1;
                            points_held    = 1'b0;
                        end
                        stroke_open = 1'b0;
                    end
                    res.pointer_x        = held_x;
                    res.pointer_y        = held_y;
                    res.pointer_down     = (found >= 0);
                    res.pointer_released = touched && (found < 0);
                    touched = (found >= 0);
                    moved   = 1'b0;
                    points      += res.point_valid;
                    stroke_ends += res.stroke_end;
                    releases    += res.pointer_released;
                    frame_q.insert(frame_q.size(), res);
                end
                default: ;
            endcase
        endfunction

        // compare one delivered frame result with the oldest prediction
        function void check_result(mts_pkg::t_out_item got);
            mts_pkg::t_out_item want;
            bit                 bad;
            frames_seen++;
            if (frame_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected frame result: x=%0d y=%0d down=%0b",
                             $signed(got.pointer_x), got.pointer_y, got.pointer_down);
                return;
            end
            want = frame_q.pop_front();
            bad  = 1'b0;
            if (got.pointer_x !== want.pointer_x) bad = 1'b1;
            if (got.pointer_y !== want.pointer_y) bad = 1'b1;
            if (got.pointer_down !== want.pointer_down) bad = 1'b1;
            if (got.pointer_released !== want.pointer_released) bad = 1'b1;
            if (got.point_valid !== want.point_valid) bad = 1'b1;
            if (got.stroke_end !== want.stroke_end) bad = 1'b1;
            if (bad) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("frame %0d expected x=%0d y=%0d dn=%0b rel=%0b pt=%0b end=%0b",
                             frames_seen, $signed(want.pointer_x), want.pointer_y,
                             want.pointer_down, want.pointer_released,
                             want.point_valid, want.stroke_end);
                    $display("frame %0d actual   x=%0d y=%0d dn=%0b rel=%0b pt=%0b end=%0b",
                             frames_seen, $signed(got.pointer_x), got.pointer_y,
                             got.pointer_down, got.pointer_released,
                             got.point_valid, got.stroke_end);
                end
            end
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    mts_pkg::t_in_item         in_item = '0;
    logic                      out_stall = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [mts_pkg::POS_W-1:0] cfg_wr_data = '0;
    logic                      o_in_stall;
    logic                      o_out_valid;
    mts_pkg::t_out_item        o_out_item;

    slot_scoreboard sb = new();

    int fed_items = 0;
    int sent_total = 0;
    int width_writes = 0;
    int long_holds = 0;
    int idle_cycles = 0;
    bit hold_request = 1'b0;
    bit snd_calm = 1'b0;
    int snd_left = 0;
    bit rcv_calm = 1'b0;
    int rcv_left = 0;

    multitouch_slot_tracker #(
        .NUM_SLOTS(NUM_SLOTS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(in_valid),
        .o_in_stall(o_in_stall),
        .i_in_item(in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_item(o_out_item),
        .i_cfg_wr_en(cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // per-request wait, with stretches where a side never idles
    function automatic int draw_wait(inout bit calm, inout int left);
        if (left == 0) begin
            calm = ($urandom_range(0, 3) == 0);
            left = $urandom_range(20, 60);
        end
        left--;
        return calm ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic mts_pkg::t_in_item make_item(logic [1:0] cmd, logic [2:0] code,
                                                    logic [31:0] v, logic blk);
        mts_pkg::t_in_item it;
        it.cmd           = cmd;
        it.axis_code     = code;
        it.value         = v;
        it.block_drawing = blk;
        return it;
    endfunction

    // mostly on-panel values, some negative and some past the maximum
    function automatic logic [31:0] draw_position();
        case ($urandom_range(0, 9))
            0: return $urandom | 32'h8000_0000;
            1: return $urandom_range(4096, 32'h7FFF_FFFF);
            2: return $urandom_range(4090, 4100);
            default: return $urandom_range(0, 4095);
        endcase
    endfunction

    task automatic send_request(mts_pkg::t_in_item it);
        int gap;
        gap = draw_wait(snd_calm, snd_left);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_request(it);
        sent_total++;
        if (!(it.cmd == CMD_UNUSED ||
              (it.cmd == mts_pkg::CMD_AXIS && it.axis_code >= AXIS_IGNORED)))
            fed_items++;
    endtask

    // drop valid, wait for every frame result, then let the pipe empty
    task automatic settle_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_width(logic [mts_pkg::POS_W-1:0] w);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        sb.set_width(w);
        width_writes++;
    endtask

    // one touch gesture: slot select, maybe an id, a few positions, a tick
    task automatic send_gesture();
        logic [31:0] v;
        int          n;
        case ($urandom_range(0, 9))
            0: v = $urandom;
            1: v = $urandom_range(NUM_SLOTS, 15);
            2, 3: v = $urandom_range(0, NUM_SLOTS - 1);
            default: v = $urandom_range(0, 3);
        endcase
        send_request(make_item(mts_pkg::CMD_AXIS, mts_pkg::AXIS_SLOT, v,
                               1'($urandom_range(0, 1))));
        if ($urandom_range(0, 3) != 0) begin
            if ($urandom_range(0, 4) < 2) v = 32'hFFFF_FFFF - $urandom_range(0, 1000);
            else v = $urandom_range(0, 65535);
            send_request(make_item(mts_pkg::CMD_AXIS, mts_pkg::AXIS_TRK_ID, v,
                                   1'($urandom_range(0, 1))));
        end
        n = $urandom_range(0, 3);
        repeat (n)
            send_request(make_item(mts_pkg::CMD_AXIS,
                                   $urandom_range(0, 1) ? mts_pkg::AXIS_POS_X
                                                        : mts_pkg::AXIS_POS_Y,
                                   draw_position(), 1'($urandom_range(0, 1))));
        send_request(make_item(mts_pkg::CMD_TICK, 3'($urandom_range(0, 7)), $urandom,
                               ($urandom_range(0, 4) == 0)));
    endtask

    task automatic send_random_phase();
        int goal;
        goal = fed_items + PHASE_ITEMS;
        while (fed_items < goal) begin
            case ($urandom_range(0, 9))
                0: send_request(make_item(mts_pkg::CMD_CLEAR, 3'($urandom_range(0, 7)),
                                          $urandom, 1'($urandom_range(0, 1))));
                1: send_request(make_item(mts_pkg::CMD_TICK, 3'($urandom_range(0, 7)),
                                          $urandom, 1'($urandom_range(0, 1))));
                2: send_request(make_item(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                                          $urandom, 1'($urandom_range(0, 1))));
                default: send_gesture();
            endcase
        end
    endtask

    task automatic send_directed();
        // tick straight out of reset: nothing touched
        send_request(make_item(mts_pkg::CMD_TICK, mts_pkg::AXIS_SLOT, '0, 1'b0));
        // slot select: negative, positive beyond range, top slot
        send_request(make_item(mts_pkg::CMD_AXIS, mts_pkg::AXIS_SLOT, 32'hFFFF_FFFF, 1'b0));
        send_request(make_item(mts_pkg::CMD_AXIS, mts_pkg::AXIS_SLOT, 32'h7FFF_FFFF, 1'b1));
        send_request(make_item(mts_pkg::CMD_AXIS, mts_pkg::AXIS_SLOT, NUM_SLOTS - 1, 1'b0));
        send_request(make_item(mts_pkg::CMD_AXIS, mts_pkg::AXIS_TRK_ID, 32'd0, 1'b0));
        // saturation at both ends
        send_request(make_item(mts_pkg::CMD_AXIS, mts_pkg::AXIS_POS_X, 32'h7FFF_FFFF, 1'b0));
        send_request(make_item(mts_pkg::CMD_AXIS, mts_pkg::AXIS_POS_Y, 32'h8000_0000, 1'b0));
        // ignored axis codes and the unused command
        send_request(make_item(mts_pkg::CMD_AXIS, AXIS_IGNORED, 32'h5555_AAAA, 1'b1));
        send_request(make_item(mts_pkg::CMD_AXIS, AXIS_TOP, 32'hAAAA_5555, 1'b0));
        send_request(make_item(CMD_UNUSED, AXIS_TOP, 32'hFFFF_FFFF, 1'b1));
        send_request(make_item(mts_pkg::CMD_TICK, mts_pkg::AXIS_SLOT, '0, 1'b0));
        // slot 0 over slot 9, pointer x goes negative
        send_request(make_item(mts_pkg::CMD_AXIS, mts_pkg::AXIS_SLOT, NUM_SLOTS, 1'b0));
        send_request(make_item(mts_pkg::CMD_AXIS, mts_pkg::AXIS_TRK_ID, 32'd5, 1'b0));
        send_request(make_item(mts_pkg::CMD_AXIS, mts_pkg::AXIS_POS_Y, 32'd4095, 1'b0));
        send_request(make_item(mts_pkg::CMD_AXIS, mts_pkg::AXIS_POS_X, 32'd4096, 1'b0));
        send_request(make_item(mts_pkg::CMD_TICK, mts_pkg::AXIS_SLOT, '0, 1'b1));
        send_request(make_item(mts_pkg::CMD_AXIS, mts_pkg::AXIS_POS_X, 32'd0, 1'b0));
        send_request(make_item(mts_pkg::CMD_TICK, mts_pkg::AXIS_SLOT, '0, 1'b0));
        // clear drops points, then all slots lift: release without stroke end
        send_request(make_item(mts_pkg::CMD_CLEAR, mts_pkg::AXIS_SLOT, '0, 1'b0));
        send_request(make_item(mts_pkg::CMD_AXIS, mts_pkg::AXIS_TRK_ID, 32'hFFFF_FFFF, 1'b0));
        send_request(make_item(mts_pkg::CMD_AXIS, mts_pkg::AXIS_SLOT, NUM_SLOTS - 1, 1'b0));
        send_request(make_item(mts_pkg::CMD_AXIS, mts_pkg::AXIS_TRK_ID, 32'h8000_0000, 1'b0));
        send_request(make_item(mts_pkg::CMD_TICK, mts_pkg::AXIS_SLOT, '0, 1'b0));
        // touch, draw a point, lift: stroke end
        send_request(make_item(mts_pkg::CMD_AXIS, mts_pkg::AXIS_TRK_ID, 32'h7FFF_FFFF, 1'b0));
        send_request(make_item(mts_pkg::CMD_AXIS, mts_pkg::AXIS_POS_Y, 32'd100, 1'b0));
        send_request(make_item(mts_pkg::CMD_TICK, mts_pkg::AXIS_SLOT, '0, 1'b0));
        send_request(make_item(mts_pkg::CMD_AXIS, mts_pkg::AXIS_TRK_ID, 32'hFFFF_FFFE, 1'b0));
        send_request(make_item(mts_pkg::CMD_TICK, mts_pkg::AXIS_SLOT, '0, 1'b0));
    endtask

    // result receiver with random stall and an occasional long hold-off
    initial begin
        int hold;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            hold = draw_wait(rcv_calm, rcv_left);
            if (hold_request) begin
                hold_request = 1'b0;
                hold = LONG_HOLD;
                long_holds++;
            end
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !out_stall)
            sb.check_result(o_out_item);
    end

    // watchdog on cycles with no accepted request and no delivered result
    initial begin
        wait (i_rst_n === 1'b1);
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog expired after %0d idle cycles", WATCHDOG_LIMIT);
        $display("multitouch_slot_tracker: mismatch");
        $finish;
    end

    // main sequence
    initial begin
        logic [mts_pkg::POS_W-1:0] widths [5];
        widths[0] = '0;
        widths[1] = mts_pkg::POS_MAX;
        widths[2] = 12'($urandom_range(1, 4094));
        widths[3] = 12'd1;
        widths[4] = mts_pkg::SCREEN_WIDTH_INIT;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_directed();
        settle_idle();
        for (int ph = 0; ph < 5 && fed_items < ITEM_TARGET; ph++) begin
            write_width(widths[ph]);
            if (ph == 1 || ph == 3) hold_request = 1'b1;
            send_random_phase();
            settle_idle();
        end
        $display("sent %0d requests (%0d effective) over %0d screen widths",
                 sent_total, fed_items, width_writes + 1);
        $display("checked %0d frames: %0d points, %0d stroke ends, %0d releases, %0d long holds",
                 sb.frames_seen, sb.points, sb.stroke_ends, sb.releases, long_holds);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("multitouch_slot_tracker: match");
        else
            $display("multitouch_slot_tracker: mismatch");
        $finish;
    end

endmodule
